@@ rtl/qrd_pkg.sv @@
package qrd_pkg;

    localparam int SIDE       = 21;
    localparam int MAX_BYTES  = 24;
    localparam int ROW_W      = SIDE;
    localparam int IDX_W      = 5;
    localparam int BIT_W      = 8;
    localparam int CNT_W      = 9;
    localparam int COUNT_LAST = 11;
    localparam int DATA_FIRST = 12;
    localparam int BYTE_END0  = DATA_FIRST + 7;
    localparam int LAST_ROW   = SIDE - 1;
    localparam int TIMING     = 6;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } row_entry_t;

    typedef enum logic {
        BK_LOAD,
        BK_WALK
    } back_state_t;

    function automatic logic skipped(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y);
        logic hit;
        hit = 1'b0;
        if (y <= IDX_W'(8) && x <= IDX_W'(8))
        begin
            hit = 1'b1;
        end
        if (y <= IDX_W'(8) && x >= IDX_W'(13))
        begin
            hit = 1'b1;
        end
        if (y >= IDX_W'(13) && x <= IDX_W'(8))
        begin
            hit = 1'b1;
        end
        if (x == IDX_W'(TIMING) || y == IDX_W'(TIMING))
        begin
            hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

@@ rtl/qr_v1_matrix_byte_decoder.sv @@
// Row items: one accepted per cycle while the two-entry row queue has room.
// After the last row the back end walks the zigzag one module per cycle, but holds at a
// module that emits a result while the output register is stalled, and stops at the last
// result of the matrix: the empty marker for a zero count, else the last of at most 24 bytes.
// That last result is registered in the output register.
// Reset (rst_n, asynchronous, active low) clears the row count, the queue and the output
// valid; stored rows are undefined until written.
module qr_v1_matrix_byte_decoder
    import qrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             row_valid,
    output logic             row_stall,
    input  logic [ROW_W-1:0] row_bits,
    input  logic             first_row,
    output logic             byte_valid,
    input  logic             byte_stall,
    output logic [7:0]       data_byte,
    output logic             last_byte,
    output logic             empty_message,
    output logic             count_clipped
);

    logic       q_full;
    logic       push;
    row_entry_t push_entry;
    logic       q_valid;
    row_entry_t q_entry;
    logic       q_pop;

    qrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_valid  (row_valid),
        .row_bits   (row_bits),
        .first_row  (first_row),
        .row_stall  (row_stall),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    qrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (q_pop)
    );

    qrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .count_clipped (count_clipped),
        .byte_stall    (byte_stall)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty row queue");

    a_walk_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.last) |=> !q_pop)
        else $error("row popped while decode walk runs");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && empty_message) |-> (last_byte && !count_clipped && data_byte == 8'd0))
        else $error("malformed empty marker");
`endif

endmodule

@@ rtl/qrd_front.sv @@
module qrd_front
    import qrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             row_valid,
    input  logic [ROW_W-1:0] row_bits,
    input  logic             first_row,
    output logic             row_stall,
    input  logic             q_full,
    output logic             push,
    output row_entry_t       push_entry
);

    logic [IDX_W-1:0] rows_loaded_reg;
    logic [IDX_W-1:0] rows_loaded_next;
    logic [IDX_W-1:0] idx;
    logic             last;

    assign row_stall = q_full;
    assign push      = row_valid && !q_full;

    always_comb
    begin
        idx = first_row ? '0 : rows_loaded_reg;
        if (idx >= IDX_W'(SIDE))
        begin
            idx = '0;
        end
        last = (idx == IDX_W'(LAST_ROW));
        rows_loaded_next = rows_loaded_reg;
        if (push)
        begin
            rows_loaded_next = last ? '0 : IDX_W'(idx + IDX_W'(1));
        end
    end

    assign push_entry.row  = row_bits;
    assign push_entry.idx  = idx;
    assign push_entry.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_loaded_reg <= '0;
        end
        else
        begin
            rows_loaded_reg <= rows_loaded_next;
        end
    end

endmodule

@@ rtl/qrd_queue.sv @@
module qrd_queue
    import qrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  row_entry_t push_entry,
    output logic       full,
    output logic       q_valid,
    output row_entry_t q_entry,
    input  logic       pop
);

    row_entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/qrd_back.sv @@
module qrd_back
    import qrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  row_entry_t       q_entry,
    output logic             q_pop,
    output logic             byte_valid,
    output logic [7:0]       data_byte,
    output logic             last_byte,
    output logic             empty_message,
    output logic             count_clipped,
    input  logic             byte_stall
);

    logic [ROW_W-1:0] rows_mem [SIDE];

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             walk_en;

    logic [IDX_W-1:0] right_reg;
    logic [IDX_W-1:0] right_next;
    logic [IDX_W-1:0] y_reg;
    logic [IDX_W-1:0] y_next;
    logic             xsel_reg;
    logic             xsel_next;
    logic             up_reg;
    logic             up_next;
    logic [BIT_W-1:0] n_reg;
    logic [BIT_W-1:0] n_next;
    logic [7:0]       cnt_sh_reg;
    logic [7:0]       cnt_sh_next;
    logic [IDX_W-1:0] cnt_eff_reg;
    logic [IDX_W-1:0] cnt_eff_next;
    logic             clip_reg;
    logic             clip_next;
    logic [6:0]       byte_sh_reg;
    logic [6:0]       byte_sh_next;
    logic [IDX_W-1:0] byte_idx_reg;
    logic [IDX_W-1:0] byte_idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       data_byte_reg;
    logic [7:0]       data_byte_next;
    logic             last_byte_reg;
    logic             last_byte_next;
    logic             empty_reg;
    logic             empty_next;
    logic             clipped_reg;
    logic             clipped_next;

    logic [IDX_W-1:0] x;
    logic [ROW_W-1:0] cur_row;
    logic             active;
    logic             mbit;
    logic [CNT_W-1:0] cnt_full;
    logic             at_count;
    logic             at_byte;
    logic             zero_cnt;
    logic             byte_last;
    logic             emit_want;
    logic             out_busy;
    logic             adv;
    logic             end_col;
    logic             walk_end;
    logic             done;
    logic             start;

    assign x        = IDX_W'(right_reg - IDX_W'(xsel_reg));
    assign cur_row  = rows_mem[y_reg];
    assign active   = !skipped(x, y_reg);
    assign mbit     = cur_row[x] ^ !(x[0] ^ y_reg[0]);
    assign cnt_full = {cnt_sh_reg, mbit};
    assign at_count = (n_reg == BIT_W'(COUNT_LAST));
    assign at_byte  = (n_reg >= BIT_W'(BYTE_END0)) && (n_reg[2:0] == 3'(BYTE_END0));
    assign zero_cnt = (cnt_full == '0);
    assign byte_last = (IDX_W'(byte_idx_reg + IDX_W'(1)) == cnt_eff_reg);
    assign emit_want = active && ((at_count && zero_cnt) || at_byte);
    assign out_busy  = out_valid_reg && byte_stall;
    assign adv       = walk_en && !(emit_want && out_busy);
    assign end_col   = up_reg ? (y_reg == '0) : (y_reg == IDX_W'(LAST_ROW));
    assign walk_end  = (right_reg == IDX_W'(1)) && xsel_reg && end_col;
    assign done      = adv && ((emit_want && ((at_count && zero_cnt) || byte_last))
                               || walk_end);
    assign start     = q_pop && q_entry.last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (start)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (done)
                begin
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_comb
    begin
        q_pop   = 1'b0;
        walk_en = 1'b0;
        case (state_reg)
            BK_LOAD:
            begin
                q_pop = q_valid;
            end
            BK_WALK:
            begin
                walk_en = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        right_next    = right_reg;
        y_next        = y_reg;
        xsel_next     = xsel_reg;
        up_next       = up_reg;
        n_next        = n_reg;
        cnt_sh_next   = cnt_sh_reg;
        cnt_eff_next  = cnt_eff_reg;
        clip_next     = clip_reg;
        byte_sh_next  = byte_sh_reg;
        byte_idx_next = byte_idx_reg;

        out_valid_next = out_valid_reg && byte_stall;
        data_byte_next = data_byte_reg;
        last_byte_next = last_byte_reg;
        empty_next     = empty_reg;
        clipped_next   = clipped_reg;

        if (start)
        begin
            right_next    = IDX_W'(LAST_ROW);
            y_next        = IDX_W'(LAST_ROW);
            xsel_next     = 1'b0;
            up_next       = 1'b1;
            n_next        = '0;
            byte_idx_next = '0;
        end
        else if (adv)
        begin
            if (!xsel_reg)
            begin
                xsel_next = 1'b1;
            end
            else
            begin
                xsel_next = 1'b0;
                if (!end_col)
                begin
                    y_next = up_reg ? IDX_W'(y_reg - IDX_W'(1)) : IDX_W'(y_reg + IDX_W'(1));
                end
                else
                begin
                    up_next    = !up_reg;
                    right_next = (right_reg == IDX_W'(TIMING + 2)) ? IDX_W'(TIMING - 1)
                                                                   : IDX_W'(right_reg - IDX_W'(2));
                end
            end

            if (active)
            begin
                n_next = BIT_W'(n_reg + BIT_W'(1));
                if (n_reg < BIT_W'(COUNT_LAST))
                begin
                    cnt_sh_next = {cnt_sh_reg[6:0], mbit};
                end
                if (at_count)
                begin
                    clip_next    = (cnt_full > CNT_W'(MAX_BYTES));
                    cnt_eff_next = clip_next ? IDX_W'(MAX_BYTES) : cnt_full[IDX_W-1:0];
                end
                if (n_reg >= BIT_W'(DATA_FIRST))
                begin
                    byte_sh_next = {byte_sh_reg[5:0], mbit};
                end
                if (at_byte)
                begin
                    byte_idx_next = IDX_W'(byte_idx_reg + IDX_W'(1));
                end
            end

            if (emit_want)
            begin
                out_valid_next = 1'b1;
                if (at_count)
                begin
                    data_byte_next = '0;
                    last_byte_next = 1'b1;
                    empty_next     = 1'b1;
                    clipped_next   = 1'b0;
                end
                else
                begin
                    data_byte_next = {byte_sh_reg, mbit};
                    last_byte_next = byte_last;
                    empty_next     = 1'b0;
                    clipped_next   = clip_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rows_mem[q_entry.idx] <= q_entry.row;
        end
        right_reg     <= right_next;
        y_reg         <= y_next;
        xsel_reg      <= xsel_next;
        up_reg        <= up_next;
        n_reg         <= n_next;
        cnt_sh_reg    <= cnt_sh_next;
        cnt_eff_reg   <= cnt_eff_next;
        clip_reg      <= clip_next;
        byte_sh_reg   <= byte_sh_next;
        byte_idx_reg  <= byte_idx_next;
        data_byte_reg <= data_byte_next;
        last_byte_reg <= last_byte_next;
        empty_reg     <= empty_next;
        clipped_reg   <= clipped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign byte_valid    = out_valid_reg;
    assign data_byte     = data_byte_reg;
    assign last_byte     = last_byte_reg;
    assign empty_message = empty_reg;
    assign count_clipped = clipped_reg;

endmodule
